>>> design/swfmd_pkg.sv
// Shared types and constants for the stereo wow and flutter modulated delay.
package swfmd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_WAVEFORM = 3'd0;
   localparam logic [2:0] REG_BYPASS   = 3'd1;
   localparam logic [2:0] REG_BASE     = 3'd2;
   localparam logic [2:0] REG_SPREAD   = 3'd3;
   localparam logic [2:0] REG_SEED     = 3'd4;

   // Waveform codes.
   localparam logic [1:0] WAVE_SINUSOID = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_GLIDE    = 2'd2;
   localparam logic [1:0] WAVE_STEP     = 2'd3;

   // Register reset values.
   localparam logic [25:0] BASE_RESET   = 26'd31457280;
   localparam logic [25:0] SPREAD_RESET = 26'd7864320;
   localparam logic [31:0] SEED_RESET   = 32'h9E37_79B9;

   // Glide coefficient, 0.0008 in Q0.32.
   localparam logic [21:0] GLIDE_COEF = 22'd3435974;

   // Q30 sine polynomial coefficients.
   localparam logic [31:0] POLY_A = 32'd1686629713;
   localparam logic [31:0] POLY_B = 32'd693598668;
   localparam logic [31:0] POLY_C = 32'd85569306;
   localparam logic [31:0] POLY_D = 32'd5026995;

   // Commands from the frame sequencer to each channel lane.
   typedef struct packed {
      logic       start;
      logic [1:0] waveform;
      logic       wr_en;
   } lane_cmd_type;

endpackage

>>> design/swfmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swfmd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/swfmd_lane.sv
// One channel lane: LFO waveform, modulated delay, history read and Hermite interpolation.
module swfmd_lane #(
   parameter int DELAY_DEPTH      = 1024,
   parameter int SAMPLE_BITS      = 24,
   parameter int SINE_TABLE_DEPTH = 1024,
   localparam int ABITS = $clog2(DELAY_DEPTH),
   localparam int HW    = SAMPLE_BITS + 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swfmd_pkg::lane_cmd_type       cmd,
   input  logic [31:0]                   phase,
   input  logic signed [31:0]            level,
   input  logic [24:0]                   depth,
   input  logic [26:0]                   base,
   input  logic [ABITS-1:0]              slot,
   input  logic                          wrapped,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   output logic                          done,
   output logic signed [HW-1:0]          wet
);

   localparam int SLOG = $clog2(SINE_TABLE_DEPTH);
   localparam int DW   = (ABITS + 18 > 30) ? ABITS + 18 : 30;
   localparam logic signed [DW-1:0] DLO = DW'(65536);
   localparam logic signed [DW-1:0] DHI = DW'(64'(DELAY_DEPTH - 2) << 16);
   localparam logic [31:0] LOW_MASK = 32'hFFFF_FFFF >> SLOG;

   typedef enum logic [6:0] {
      L_IDLE = 7'b0000001,
      L_SINE = 7'b0000010,
      L_MOD  = 7'b0000100,
      L_DLY  = 7'b0001000,
      L_READ = 7'b0010000,
      L_HERM = 7'b0100000,
      L_DONE = 7'b1000000
   } lane_state_type;

   lane_state_type state_ff, state_in;
   logic [2:0]  step_ff;
   logic [31:0] x2_ff, r_ff;
   logic signed [23:0] mod_ff;
   logic signed [49:0] prod_ff;
   logic [ABITS+15:0]  dly_ff;
   logic               vld_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff [4];
   logic signed [HW-1:0] t_ff, wet_ff;

   // Sine operand from the quantized phase, folded to the first quadrant.
   logic [31:0] tq;
   logic [30:0] xs;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [31:0] sh;
   logic [31:0] yr;
   logic [22:0] ylim;
   logic signed [23:0] sine_v, tri_v, rnd_v, mod_sel;
   logic [31:0] dt;
   logic signed [25:0] tv;

   always_comb begin
      tq = phase & ~LOW_MASK;
      xs = tq[30] ? (31'h4000_0000 - {1'b0, tq[29:0]}) : {1'b0, tq[29:0]};
      mul_a = x2_ff;
      mul_b = r_ff;
      case (step_ff)
         3'd0: begin
            mul_a = {1'b0, xs};
            mul_b = {1'b0, xs};
         end
         3'd1: begin
            mul_a = x2_ff;
            mul_b = swfmd_pkg::POLY_D;
         end
         3'd4: begin
            mul_a = {1'b0, xs};
            mul_b = r_ff;
         end
         default: begin
            mul_a = x2_ff;
            mul_b = r_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
      sh = mul_p[61:30];
      yr = (sh + 32'd64) >> 7;
      ylim = (yr > 32'd8388607) ? 23'h7F_FFFF : yr[22:0];
      sine_v = tq[31] ? -$signed({1'b0, ylim}) : $signed({1'b0, ylim});

      dt = phase[31] ? {1'b0, phase[30:0]} : (32'h8000_0000 - phase);
      tv = $signed({1'b0, dt[31:7]}) - 26'sd8388608;
      tri_v = (tv > 26'sd8388607) ? 24'sh7F_FFFF : tv[23:0];

      rnd_v = level[31:8];

      case (cmd.waveform)
         swfmd_pkg::WAVE_TRIANGLE: mod_sel = tri_v;
         swfmd_pkg::WAVE_GLIDE:    mod_sel = rnd_v;
         swfmd_pkg::WAVE_STEP:     mod_sel = rnd_v;
         default:                  mod_sel = sine_v;
      endcase
   end

   // Delay in Q16, clamped to the usable span of the history.
   logic signed [DW-1:0] dsum, dclamp;

   always_comb begin
      dsum = DW'($signed({1'b0, base})) + DW'($signed(prod_ff[49:23]));
      if (dsum < DLO) begin
         dclamp = DLO;
      end else if (dsum > DHI) begin
         dclamp = DHI;
      end else begin
         dclamp = dsum;
      end
   end

   // History read: taps at b+1, b, b-1, b-2 with b = slot - integer delay.
   logic [ABITS-1:0] tap_b, rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   assign tap_b   = slot - dly_ff[ABITS+15:16];
   assign rd_addr = tap_b + ABITS'(1) - ABITS'(step_ff);

   swfmd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DELAY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (slot),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Hermite coefficients and the shared Q16 multiplier.
   logic signed [HW-1:0] em1, e0, e1, e2, c2, v2, w2, a2, b2, mop;
   logic signed [16:0]   fq;
   logic signed [HW+16:0] pm;
   logic signed [HW-1:0]  pq;

   always_comb begin
      em1 = HW'(smp_ff[0]);
      e0  = HW'(smp_ff[1]);
      e1  = HW'(smp_ff[2]);
      e2  = HW'(smp_ff[3]);
      c2  = e1 - em1;
      v2  = (e0 - e1) <<< 1;
      w2  = c2 + v2;
      a2  = w2 + v2 + (e2 - e0);
      b2  = w2 + a2;
      fq  = $signed({1'b0, dly_ff[15:0]});
      mop = (step_ff == 3'd0) ? a2 : t_ff;
      pm  = mop * fq;
      pq  = HW'(pm >>> 16);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE: if (cmd.start) state_in = L_SINE;
         L_SINE: if (step_ff == 3'd4) state_in = L_MOD;
         L_MOD:  state_in = L_DLY;
         L_DLY:  state_in = L_READ;
         L_READ: if (step_ff == 3'd4) state_in = L_HERM;
         L_HERM: if (step_ff == 3'd2) state_in = L_DONE;
         L_DONE: state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff != state_in) begin
            step_ff <= 3'd0;
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         L_SINE: begin
            case (step_ff)
               3'd0: x2_ff <= sh;
               3'd1: r_ff  <= swfmd_pkg::POLY_C - sh;
               3'd2: r_ff  <= swfmd_pkg::POLY_B - sh;
               3'd3: r_ff  <= swfmd_pkg::POLY_A - sh;
               default: mod_ff <= mod_sel;
            endcase
         end
         L_MOD: prod_ff <= mod_ff * $signed({1'b0, depth});
         L_DLY: dly_ff <= dclamp[ABITS+15:0];
         L_READ: begin
            vld_ff <= wrapped || (rd_addr < slot);
            if (step_ff != 3'd0) begin
               smp_ff[2'(step_ff - 3'd1)] <= vld_ff ? $signed(rd_data) : '0;
            end
         end
         L_HERM: begin
            case (step_ff)
               3'd0: t_ff <= HW'(pm) - (b2 <<< 16);
               3'd1: t_ff <= pq + (c2 <<< 16);
               default: wet_ff <= (e0 <<< 17) + pq;
            endcase
         end
         default: ;
      endcase
   end

   assign done = (state_ff == L_DONE);
   assign wet  = wet_ff;

endmodule

>>> design/stereo_wow_flutter_modulated_delay.sv
// Top level of the stereo wow and flutter modulated delay: LFO, lanes, mix and handshakes.
// An active frame passes the LFO level update, the lane sequence and the mix; a bypassed
// frame goes straight to the output register. A new input transfer is taken only after the
// result is registered, which a stalled output delays. The lane sequence sets the pace:
// five sine polynomial steps, five RAM reads and three Hermite multiplies.
// Reset is synchronous, active high; the history reads as zero until each slot is written.
module stereo_wow_flutter_modulated_delay #(
   parameter int DELAY_DEPTH      = 1024,
   parameter int SAMPLE_BITS      = 24,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_left_in,
   input  logic [SAMPLE_BITS-1:0] req_right_in,
   input  logic [31:0]            req_phase_step,
   input  logic [24:0]            req_depth_samples,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_left_out,
   output logic [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int ABITS = $clog2(DELAY_DEPTH);
   localparam int HW    = SAMPLE_BITS + 26;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LEVEL = 4'b0010,
      S_LANE  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   // Configuration registers. The seed only matters as a reload of the generator,
   // which the sequencer below takes directly from the write.
   logic [1:0]  waveform_ff;
   logic        bypass_ff;
   logic [25:0] base_ff, spread_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= swfmd_pkg::WAVE_SINUSOID;
         bypass_ff   <= 1'b0;
         base_ff     <= swfmd_pkg::BASE_RESET;
         spread_ff   <= swfmd_pkg::SPREAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            swfmd_pkg::REG_WAVEFORM: waveform_ff <= csr_wdata[1:0];
            swfmd_pkg::REG_BYPASS:   bypass_ff   <= csr_wdata[0];
            swfmd_pkg::REG_BASE:     base_ff     <= csr_wdata[25:0];
            swfmd_pkg::REG_SPREAD:   spread_ff   <= csr_wdata[25:0];
            default: ;
         endcase
      end
   end

   // Frame sequencer state.
   state_type state_ff, state_in;
   logic      req_xfer, rsp_xfer, out_load;
   logic      byp_ff, carry_ff, wrapped_ff, rsp_valid_ff;
   logic [ABITS-1:0] slot_ff;
   logic [31:0] phase_ff, noise_ff;
   logic signed [23:0] goal_ff;
   logic signed [31:0] level_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff, left_out_ff, right_out_ff;
   logic [24:0] depth_ff;
   logic done_l, done_r;
   logic signed [HW-1:0] wet_l, wet_r;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Phase advance; its carry out marks a wrap, which steps the xorshift generator.
   logic [32:0] phase_sum;
   logic [31:0] ns1, ns2, ns3;

   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, req_phase_step};
      ns1 = noise_ff ^ (noise_ff << 13);
      ns2 = ns1 ^ (ns1 >> 17);
      ns3 = ns2 ^ (ns2 << 5);
   end

   // One-pole glide of the random level toward the goal; a stepped wrap jumps first.
   logic signed [31:0] goal_wide, glide_from;
   logic signed [32:0] glide_diff;
   logic signed [55:0] glide_prod;

   always_comb begin
      goal_wide  = {goal_ff, 8'd0};
      glide_from = (carry_ff && waveform_ff == swfmd_pkg::WAVE_STEP) ? goal_wide : level_ff;
      glide_diff = 33'(goal_wide) - 33'(glide_from);
      glide_prod = glide_diff * $signed({1'b0, swfmd_pkg::GLIDE_COEF});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = bypass_ff ? S_DONE : S_LEVEL;
         end
         S_LEVEL: state_in = S_LANE;
         S_LANE:  if (done_l) state_in = S_DONE;
         S_DONE:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         phase_ff     <= '0;
         noise_ff     <= swfmd_pkg::SEED_RESET;
         goal_ff      <= '0;
         level_ff     <= '0;
         carry_ff     <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         // A seed write reloads the generator at once.
         if (csr_we && csr_index == swfmd_pkg::REG_SEED) begin
            noise_ff <= csr_wdata;
         end else if (req_xfer && !bypass_ff && phase_sum[32]) begin
            noise_ff <= ns3;
         end
         if (req_xfer) begin
            byp_ff <= bypass_ff;
            if (!bypass_ff) begin
               phase_ff <= phase_sum[31:0];
               carry_ff <= phase_sum[32];
               if (phase_sum[32]) begin
                  goal_ff <= {~ns3[31], ns3[30:8]};
               end
            end
         end
         if (state_ff == S_LEVEL) begin
            level_ff <= glide_from + 32'($signed(glide_prod[55:32]));
         end
         // The history slot advances only when an active frame is written.
         if (out_load && !byp_ff) begin
            slot_ff <= slot_ff + ABITS'(1);
            if (slot_ff == ABITS'(DELAY_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         left_ff  <= $signed(req_left_in);
         right_ff <= $signed(req_right_in);
         depth_ff <= req_depth_samples;
      end
   end

   // Both lanes run in lockstep; the right one sees the phase shifted by half an LFO period.
   swfmd_pkg::lane_cmd_type cmd;

   always_comb begin
      cmd.start    = (state_ff == S_LEVEL);
      cmd.waveform = waveform_ff;
      cmd.wr_en    = out_load && !byp_ff;
   end

   swfmd_lane #(
      .DELAY_DEPTH      (DELAY_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .phase   (phase_ff),
      .level   (level_ff),
      .depth   (depth_ff),
      .base    ({1'b0, base_ff}),
      .slot    (slot_ff),
      .wrapped (wrapped_ff),
      .wr_data (left_ff),
      .done    (done_l),
      .wet     (wet_l)
   );

   swfmd_lane #(
      .DELAY_DEPTH      (DELAY_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .phase   (phase_ff + 32'h8000_0000),
      .level   (level_ff),
      .depth   (depth_ff),
      .base    ({1'b0, base_ff} + {1'b0, spread_ff}),
      .slot    (slot_ff),
      .wrapped (wrapped_ff),
      .wr_data (right_ff),
      .done    (done_r),
      .wet     (wet_r)
   );

   // Merge: half dry plus half wet, rounded half up and saturated.
   localparam logic signed [HW:0] SAT_HI = (HW+1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [HW:0] SAT_LO = -SAT_HI - (HW+1)'(1);
   logic signed [HW:0] mix_l, mix_r;
   logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;

   always_comb begin
      mix_l = ((HW+1)'(left_ff) <<< 17) + (HW+1)'(wet_l) + (HW+1)'(131072);
      mix_r = ((HW+1)'(right_ff) <<< 17) + (HW+1)'(wet_r) + (HW+1)'(131072);
      mix_l = mix_l >>> 18;
      mix_r = mix_r >>> 18;
      if (mix_l > SAT_HI) begin
         sat_l = SAMPLE_BITS'(SAT_HI);
      end else if (mix_l < SAT_LO) begin
         sat_l = SAMPLE_BITS'(SAT_LO);
      end else begin
         sat_l = mix_l[SAMPLE_BITS-1:0];
      end
      if (mix_r > SAT_HI) begin
         sat_r = SAMPLE_BITS'(SAT_HI);
      end else if (mix_r < SAT_LO) begin
         sat_r = SAMPLE_BITS'(SAT_LO);
      end else begin
         sat_r = mix_r[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_out_ff  <= byp_ff ? left_ff : sat_l;
         right_out_ff <= byp_ff ? right_ff : sat_r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;

   // The two lanes share one command and must finish on the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LANE) |-> (done_l == done_r))
      else $error("lanes out of step");

   // The write slot moves only when an active frame's result is registered.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && slot_ff != $past(slot_ff)) |-> $past(out_load && !byp_ff))
      else $error("write slot moved outside an active frame");

   // A new result is registered only from the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the finishing state");

endmodule
